FILE: design/scrm_pkg.sv
// Shared types, codes and constants for the SPI command master with CRC retry
package scrm_pkg;

  localparam int FIFO_DEPTH = 4;

  localparam logic OP_START = 1'b0;
  localparam logic OP_XFER  = 1'b1;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [7:0] RETRY_LIMIT_RESET = 8'd3;
  localparam logic [7:0] FILL_BYTE         = 8'hFF;
  localparam logic [7:0] END_BYTE          = 8'h00;
  localparam logic [7:0] CRC_POLY          = 8'h07;
  localparam logic [7:0] CNT_MAX           = 8'hFF;

  typedef struct packed {
    logic       op;
    logic [7:0] command;
    logic [7:0] read_length;
    logic [7:0] rx_byte;
    logic       transfer_failed;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic       success;
    logic [7:0] retries_used;
    logic [7:0] hardware_failures;
    logic [7:0] crc_failures;
    logic       last;
  } result_t;

  // results caused by one input beat; res1 only used when two is set
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } group_t;

endpackage

FILE: design/scrm_core.sv
// Input register, frame sequencer state, CRC-8 and result generation
module scrm_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                in_valid,
  input  scrm_pkg::item_t     in_item,
  output logic                pending,
  output logic                push,
  output scrm_pkg::group_t    group
);

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ scrm_pkg::CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

  function automatic scrm_pkg::result_t tx_res(input logic [7:0] b);
    scrm_pkg::result_t r;
    r = '0;
    r.kind    = scrm_pkg::KIND_TX;
    r.tx_byte = b;
    return r;
  endfunction

  function automatic scrm_pkg::result_t status_res(input logic ok, input logic [7:0] ru,
                                                   input logic [7:0] hw, input logic [7:0] cf);
    scrm_pkg::result_t r;
    r = '0;
    r.kind              = scrm_pkg::KIND_STATUS;
    r.success           = ok;
    r.retries_used      = ru;
    r.hardware_failures = hw;
    r.crc_failures      = cf;
    return r;
  endfunction

  logic            item_valid;
  scrm_pkg::item_t item;

  logic [7:0] retry_limit;
  logic       busy,           busy_next;
  logic [8:0] position,       position_next;
  logic [7:0] running_crc,    running_crc_next;
  logic [7:0] attempt,        attempt_next;
  logic [7:0] hw_fail_count,  hw_fail_count_next;
  logic [7:0] crc_fail_count, crc_fail_count_next;
  logic [7:0] held_command,   held_command_next;
  logic [7:0] held_length,    held_length_next;

  logic [7:0] att_inc;
  logic       do_fail;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= in_valid;
    end
    if (in_valid) begin
      item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= scrm_pkg::RETRY_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      retry_limit <= cfg_wr_data;
    end
  end

  always_comb begin
    busy_next           = busy;
    position_next       = position;
    running_crc_next    = running_crc;
    attempt_next        = attempt;
    hw_fail_count_next  = hw_fail_count;
    crc_fail_count_next = crc_fail_count;
    held_command_next   = held_command;
    held_length_next    = held_length;
    push                = 1'b0;
    group               = '0;
    do_fail             = 1'b0;
    att_inc             = attempt + 8'd1;

    if (item_valid) begin
      if (item.op == scrm_pkg::OP_START) begin
        push                = 1'b1;
        held_command_next   = item.command;
        held_length_next    = item.read_length;
        attempt_next        = '0;
        hw_fail_count_next  = '0;
        crc_fail_count_next = '0;
        position_next       = '0;
        running_crc_next    = '0;
        if (retry_limit == 8'd0) begin
          busy_next  = 1'b0;
          group.res0 = status_res(1'b0, 8'd0, 8'd0, 8'd0);
        end else begin
          busy_next  = 1'b1;
          group.res0 = tx_res(item.command);
        end
      end else if (busy) begin
        push = 1'b1;
        if (item.transfer_failed) begin
          if (hw_fail_count != scrm_pkg::CNT_MAX) begin
            hw_fail_count_next = hw_fail_count + 8'd1;
          end
          do_fail = 1'b1;
        end else if (position == 9'd0) begin
          running_crc_next = crc8_step(8'd0, held_command);
          position_next    = 9'd1;
          group.res0 = tx_res((held_length != 8'd0) ? scrm_pkg::FILL_BYTE
                                                     : scrm_pkg::END_BYTE);
        end else if (position <= {1'b0, held_length}) begin
          running_crc_next = crc8_step(running_crc, item.rx_byte);
          position_next    = position + 9'd1;
          group.two        = 1'b1;
          group.res0            = '0;
          group.res0.kind       = scrm_pkg::KIND_DATA;
          group.res0.data_byte  = item.rx_byte;
          group.res0.data_index = 8'(position - 9'd1);
          group.res1 = tx_res((position < {1'b0, held_length}) ? scrm_pkg::FILL_BYTE
                                                                : scrm_pkg::END_BYTE);
        end else if (item.rx_byte == running_crc) begin
          busy_next  = 1'b0;
          group.res0 = status_res(1'b1, attempt, hw_fail_count, crc_fail_count);
        end else begin
          if (crc_fail_count != scrm_pkg::CNT_MAX) begin
            crc_fail_count_next = crc_fail_count + 8'd1;
          end
          do_fail = 1'b1;
        end

        if (do_fail) begin
          attempt_next = att_inc;
          if (att_inc >= retry_limit) begin
            busy_next  = 1'b0;
            group.res0 = status_res(1'b0, att_inc, hw_fail_count_next, crc_fail_count_next);
          end else begin
            position_next    = '0;
            running_crc_next = '0;
            group.res0       = tx_res(held_command);
          end
        end
      end
    end

    if (group.two) begin
      group.res1.last = 1'b1;
    end else begin
      group.res0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      position       <= '0;
      running_crc    <= '0;
      attempt        <= '0;
      hw_fail_count  <= '0;
      crc_fail_count <= '0;
      held_command   <= '0;
      held_length    <= '0;
    end else begin
      busy           <= busy_next;
      position       <= position_next;
      running_crc    <= running_crc_next;
      attempt        <= attempt_next;
      hw_fail_count  <= hw_fail_count_next;
      crc_fail_count <= crc_fail_count_next;
      held_command   <= held_command_next;
      held_length    <= held_length_next;
    end
  end

  assign pending = item_valid;

endmodule

FILE: design/scrm_res_fifo.sv
// Result queue: one group of up to two results per entry, one result per output beat
module scrm_res_fifo #(
  parameter int Depth = scrm_pkg::FIFO_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  scrm_pkg::group_t            group,
  output logic [$clog2(Depth+1)-1:0]  count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output scrm_pkg::result_t           out_res
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  scrm_pkg::group_t mem [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic             sel;
  logic             beat;
  logic             pop;

  assign out_valid = (count != '0);
  assign out_res   = sel ? mem[rd_ptr].res1 : mem[rd_ptr].res0;
  assign beat      = out_valid && out_ready;
  assign pop       = beat && (sel || !mem[rd_ptr].two);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sel    <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (beat) begin
        sel <= !pop;
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

FILE: design/spi_command_crc_retry_master.sv
// Top level of the SPI command master with CRC-8 check and frame retries
//
// s_* carries commands and transfer reports: tuser 0 starts a command (command,
// read_length used), tuser 1 reports one finished byte transfer (rx_byte,
// transfer_failed used). m_* returns results: tuser 0 is a byte to send next,
// 1 a received data byte with its index, 2 the final status; tlast marks the
// last result caused by an input beat. cfg_wr_en/cfg_wr_data write retry_limit.
// An accepted beat is registered in the input register, processed by the core and
// written into the result queue, from which its first result is presented.
// Throughput: one input beat per cycle while s_tready is high; output rate is one
// result per cycle while m_tready is high, so a data byte report (two results)
// holds the output for both. s_tready falls when the result queue, counting the
// beat in the input register, has no room left for another group; a stalled
// m_tready therefore backs up into s_tready after a few beats, with nothing lost.
// Reset clears the sequencer to idle, empties the queue and sets retry_limit
// to 3.
module spi_command_crc_retry_master #(
  parameter int FifoDepth = scrm_pkg::FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // command, read_length, rx_byte, transfer_failed, pad
  input  logic        s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  // tx_byte, data_byte, data_index, success, retries_used, hardware_failures,
  // crc_failures, pad
  output logic [55:0] m_tdata,
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast
);

  localparam int CntW = $clog2(FifoDepth + 1);

  scrm_pkg::item_t   in_item;
  scrm_pkg::group_t  group;
  scrm_pkg::result_t res;
  logic              pending;
  logic              push;
  logic [CntW-1:0]   count;

  assign in_item.op              = s_tuser;
  assign in_item.command         = s_tdata[7:0];
  assign in_item.read_length     = s_tdata[15:8];
  assign in_item.rx_byte         = s_tdata[23:16];
  assign in_item.transfer_failed = s_tdata[24];

  assign s_tready = ({1'b0, count} + (CntW+1)'(pending)) <= (CntW+1)'(FifoDepth - 1);

  scrm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_tvalid && s_tready),
    .in_item     (in_item),
    .pending     (pending),
    .push        (push),
    .group       (group)
  );

  scrm_res_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .group     (group),
    .count     (count),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tuser = res.kind;
  assign m_tlast = res.last;
  assign m_tdata = {7'd0, res.crc_failures, res.hardware_failures, res.retries_used,
                    res.success, res.data_index, res.data_byte, res.tx_byte};

endmodule
